@@ rtl/core/drs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_pkg: shared types and constants of the disk request scheduler
// Request record, policy and command codes, sequencer states and the
// control group between the sequencer and the seek compare unit.
// ----------------------------------------------------------------------------
package drs_pkg;

  // default number of waiting slots
  localparam int DRS_QUEUE_DEPTH = 16;

  // selection key: class, seek distance, arrival stamp
  localparam int KEY_W = 2 + 16 + 32;

  // policy register codes (the unused code behaves as first come first served)
  localparam logic [1:0] POL_FCFS = 2'd0;
  localparam logic [1:0] POL_SSTF = 2'd1;
  localparam logic [1:0] POL_LOOK = 2'd2;

  // request command codes
  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_DONE   = 1'b1;

  // register index (word select bit of paddr)
  localparam logic REG_POLICY = 1'b0;

  // look classes
  localparam logic [1:0] CLS_SAME  = 2'd0;
  localparam logic [1:0] CLS_AHEAD = 2'd1;
  localparam logic [1:0] CLS_BEHIND = 2'd2;

  // one request record
  typedef struct packed {
    logic [15:0] id;
    logic [31:0] arrival;
    logic [15:0] cylinder;
    logic [31:0] address;
    logic [15:0] process;
  } entry_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT
  } sched_state_t;

  // control from the sequencer to the compare unit
  typedef struct packed {
    logic clear;
    logic en;
  } cmp_ctl_t;

endpackage

@@ rtl/core/drs_queue_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_queue_mem: waiting request store
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module drs_queue_mem import drs_pkg::*; #(
  parameter int QUEUE_DEPTH = DRS_QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
  input  entry_t                         wr_data,
  input  logic                           rd_en,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
  output entry_t                         rd_data
);

  entry_t mem [QUEUE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/drs_seek_cmp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_seek_cmp: shared selection compare unit
// Builds the policy key of one slot per cycle and keeps the best slot seen
// so far, its key and its record.
// ----------------------------------------------------------------------------
module drs_seek_cmp import drs_pkg::*; #(
  parameter int QUEUE_DEPTH = DRS_QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cmp_ctl_t                       ctl,
  input  logic [1:0]                     policy,
  input  logic [15:0]                    head,
  input  logic                           up,
  input  entry_t                         cand,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] cand_slot,
  output logic [$clog2(QUEUE_DEPTH)-1:0] best_slot,
  output entry_t                         best_entry
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic             best_valid_r, best_valid_nxt;
  logic [KEY_W-1:0] best_key_r;
  logic [AW-1:0]    best_slot_r;
  entry_t           best_entry_r;
  logic             above, below, take;
  logic [15:0]      seek_gap;
  logic [1:0]       cls;
  logic [KEY_W-1:0] key;

  // distance and look class of the candidate
  always_comb begin
    above    = cand.cylinder > head;
    below    = cand.cylinder < head;
    seek_gap = above ? (cand.cylinder - head) : (head - cand.cylinder);
    if (!above && !below) begin
      cls = CLS_SAME;
    end else if (up ? above : below) begin
      cls = CLS_AHEAD;
    end else begin
      cls = CLS_BEHIND;
    end
  end

  // policy key, lower wins; strict compare keeps the lower slot on a tie
  always_comb begin
    case (policy)
      POL_SSTF: key = {CLS_SAME, seek_gap, cand.arrival};
      POL_LOOK: key = {cls, seek_gap, cand.arrival};
      default:  key = {CLS_SAME, 16'd0, cand.arrival};
    endcase
    take = ctl.en && (!best_valid_r || (key < best_key_r));
    best_valid_nxt = best_valid_r;
    if (ctl.clear) begin
      best_valid_nxt = 1'b0;
    end else if (take) begin
      best_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_valid_r <= 1'b0;
    end else begin
      best_valid_r <= best_valid_nxt;
    end
  end

  // best candidate record
  always_ff @(posedge clk) begin
    if (take) begin
      best_key_r   <= key;
      best_slot_r  <= cand_slot;
      best_entry_r <= cand;
    end
  end

  assign best_slot  = best_slot_r;
  assign best_entry = best_entry_r;

endmodule

@@ rtl/core/disk_request_scheduler.sv @@
`timescale 1ns / 1ps
// Arrival: the result is registered at accept, one request per cycle while results are taken.
// Completion: n queued entries are scanned through the single read port, then the entries
// behind the chosen one move down one a cycle; the result is registered once the gap is
// closed and the result port is free.
// Reset: synchronous; clears control, the in-service request and the policy.
// The slot store is not cleared; only slots below the fill count are read.
// ----------------------------------------------------------------------------
// disk_request_scheduler: policy-selectable disk request scheduler
// Keeps one request in service and a queue of waiting requests in arrival
// order; on completion a sequencer scans the queue with a shared compare
// unit, then closes the gap left by the chosen entry.
// ----------------------------------------------------------------------------
module disk_request_scheduler import drs_pkg::*; #(
  parameter int QUEUE_DEPTH = DRS_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [15:0] in_req_id,
  input  logic [31:0] in_req_arrival,
  input  logic [15:0] in_req_cylinder,
  input  logic [31:0] in_req_address,
  input  logic [15:0] in_req_process,
  input  logic [15:0] in_head_cylinder,
  input  logic        in_scan_up,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_serving,
  output logic [15:0] out_id,
  output logic [31:0] out_arrival,
  output logic [15:0] out_cylinder,
  output logic [31:0] out_address,
  output logic [15:0] out_process,
  output logic [4:0]  out_pending,
  output logic        out_dropped,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  sched_state_t  state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          busy_r, busy_nxt;
  entry_t        cur_r, cur_nxt;
  logic          dropped_r, dropped_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    policy_r;
  logic [15:0]   head_r, head_nxt;
  logic          up_r, up_nxt;
  logic [CW-1:0] issue_r, issue_nxt;
  logic          rv_r, rv_nxt;
  logic [AW-1:0] ridx_r, ridx_nxt;

  logic          accept, out_free, issue_more;
  entry_t        req;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data, rd_data, best_entry;
  logic [AW-1:0] best_slot;
  cmp_ctl_t      cmp_ctl;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_POLICY) ? {30'd0, policy_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_FCFS;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_POLICY)) begin
      policy_r <= pwdata[1:0];
    end
  end

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign issue_more = issue_r < count_r;

  assign req = '{id: in_req_id, arrival: in_req_arrival, cylinder: in_req_cylinder,
                 address: in_req_address, process: in_req_process};

  // sequencer: next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    busy_nxt      = busy_r;
    cur_nxt       = cur_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = out_valid_r && out_stall;
    head_nxt      = head_r;
    up_nxt        = up_r;
    issue_nxt     = issue_r;
    rv_nxt        = 1'b0;
    ridx_nxt      = ridx_r;
    wr_en         = 1'b0;
    wr_addr       = count_r[AW-1:0];
    wr_data       = req;
    rd_en         = 1'b0;
    cmp_ctl       = '{clear: 1'b0, en: 1'b0};
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          dropped_nxt = 1'b0;
          if (in_cmd == CMD_ARRIVE) begin
            out_valid_nxt = 1'b1;
            if (!busy_r) begin
              busy_nxt = 1'b1;
              cur_nxt  = req;
            end else if (count_r == CW'(QUEUE_DEPTH)) begin
              dropped_nxt = 1'b1;
            end else begin
              wr_en     = 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end else if (count_r == '0) begin
            out_valid_nxt = 1'b1;
            busy_nxt      = 1'b0;
            cur_nxt       = '0;
          end else begin
            head_nxt    = in_head_cylinder;
            up_nxt      = in_scan_up;
            issue_nxt   = '0;
            cmp_ctl.clear = 1'b1;
            state_nxt   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // one slot read a cycle, compared the cycle after
        cmp_ctl.en = rv_r;
        if (issue_more) begin
          rd_en     = 1'b1;
          rv_nxt    = 1'b1;
          ridx_nxt  = issue_r[AW-1:0];
          issue_nxt = issue_r + 1'b1;
        end else if (!rv_r) begin
          issue_nxt = CW'(best_slot) + 1'b1;
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        // move each entry behind the chosen one down by one slot
        wr_en   = rv_r;
        wr_addr = ridx_r - 1'b1;
        wr_data = rd_data;
        if (issue_more) begin
          rd_en     = 1'b1;
          rv_nxt    = 1'b1;
          ridx_nxt  = issue_r[AW-1:0];
          issue_nxt = issue_r + 1'b1;
        end else if (!rv_r && out_free) begin
          count_nxt     = count_r - 1'b1;
          cur_nxt       = best_entry;
          busy_nxt      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      busy_r      <= 1'b0;
      cur_r       <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
      rv_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      busy_r      <= busy_nxt;
      cur_r       <= cur_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
      rv_r        <= rv_nxt;
    end
  end

  // sequencer working registers
  always_ff @(posedge clk) begin
    head_r  <= head_nxt;
    up_r    <= up_nxt;
    issue_r <= issue_nxt;
    ridx_r  <= ridx_nxt;
  end

  // slot store
  drs_queue_mem #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (issue_r[AW-1:0]),
    .rd_data (rd_data)
  );

  // shared selection unit
  drs_seek_cmp #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_cmp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (cmp_ctl),
    .policy     (policy_r),
    .head       (head_r),
    .up         (up_r),
    .cand       (rd_data),
    .cand_slot  (ridx_r),
    .best_slot  (best_slot),
    .best_entry (best_entry)
  );

  // result port, held by the state itself until taken
  assign out_valid    = out_valid_r;
  assign out_serving  = busy_r;
  assign out_id       = cur_r.id;
  assign out_arrival  = cur_r.arrival;
  assign out_cylinder = cur_r.cylinder;
  assign out_address  = cur_r.address;
  assign out_process  = cur_r.process;
  assign out_pending  = 5'(count_r);
  assign out_dropped  = dropped_r;

  // fill count never passes the store size
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  // waiting requests imply one in service
  assert property (@(posedge clk) disable iff (!rst_n) (count_r != '0) |-> busy_r)
    else $error("queue holds requests while idle");

  // a scan only runs over a non-empty queue
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == ST_SCAN || state_r == ST_SHIFT) |-> (count_r != '0))
    else $error("selection started on an empty queue");

  // a waiting result keeps the scheduler state frozen
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid_r && out_stall && state_r == ST_IDLE) |=>
                   ($stable(count_r) && $stable(busy_r) && $stable(cur_r)))
    else $error("scheduler state moved under a stalled result");

  // gap closing writes stay below the fill count
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == ST_SHIFT && wr_en) |-> (CW'(wr_addr) < count_r))
    else $error("shift write outside the queue");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the disk request scheduler
// Drives arrivals and completions under every policy and predicts each
// service report. Both channels idle and stall at random, and the receiver
// holds off once for a long stretch. The policy register is written over
// the APB-style port between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import drs_pkg::*;

  localparam int QD = DRS_QUEUE_DEPTH;
  localparam int PHASE_LEN = 228;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT = 700;

  // one request as offered on the request channel
  typedef struct packed {
    logic        cmd;
    entry_t      rec;
    logic [15:0] head;
    logic        scan_up;
  } sched_req_t;

  // one service report as seen on the result channel
  typedef struct packed {
    logic       serving;
    entry_t     rec;
    logic [4:0] pending;
    logic       dropped;
  } sched_report_t;

  typedef enum int {SIDE_SAME, SIDE_ABOVE, SIDE_BELOW, SIDE_ANY} seek_side_t;

  // predicts the service report of every accepted request and checks reports
  class sched_scoreboard;
    entry_t          slots[QD];
    int unsigned     count;
    bit              busy;
    entry_t          cur;
    logic [1:0]      policy;
    sched_report_t   due[$];
    int              errors;

    function void clear_state();
      count = 0;
      busy = 1'b0;
      cur = '0;
      policy = POL_FCFS;
      errors = 0;
      due.delete();
    endfunction

    function void set_policy(logic [1:0] code);
      policy = code;
    endfunction

    function logic [15:0] seek_dist(logic [15:0] a, logic [15:0] b);
      return (a > b) ? a - b : b - a;
    endfunction

    // distance first, then earlier arrival; equal keeps the lower slot
    function bit beats(int best, int i, logic [15:0] head);
      logic [15:0] di;
      logic [15:0] db;
      if (best < 0) return 1'b1;
      di = seek_dist(slots[i].cylinder, head);
      db = seek_dist(slots[best].cylinder, head);
      if (di != db) return di < db;
      return slots[i].arrival < slots[best].arrival;
    endfunction

    function int best_on_side(seek_side_t side, logic [15:0] head);
      int best;
      logic [15:0] c;
      bit ok;
      best = -1;
      for (int i = 0; i < count; i++) begin
        c = slots[i].cylinder;
        ok = (side == SIDE_SAME && c == head) || (side == SIDE_ABOVE && c > head) ||
             (side == SIDE_BELOW && c < head) || side == SIDE_ANY;
        if (ok && beats(best, i, head)) best = i;
      end
      return best;
    endfunction

    function int choose_slot(logic [15:0] head, logic up);
      int k;
      case (policy)
        POL_SSTF: begin
          k = best_on_side(SIDE_ANY, head);
        end
        POL_LOOK: begin
          k = best_on_side(SIDE_SAME, head);
          if (k < 0) k = best_on_side(up ? SIDE_ABOVE : SIDE_BELOW, head);
          if (k < 0) k = best_on_side(up ? SIDE_BELOW : SIDE_ABOVE, head);
        end
        default: begin
          // first come first served, also for the unused code
          k = 0;
          for (int i = 1; i < count; i++)
            if (slots[i].arrival < slots[k].arrival) k = i;
        end
      endcase
      if (k < 0) k = 0;
      return k;
    endfunction

    function void note_request(sched_req_t r);
      sched_report_t rep;
      int k;
      bit drop;
      drop = 1'b0;
      if (r.cmd == CMD_ARRIVE) begin
        if (!busy) begin
          busy = 1'b1;
          cur = r.rec;
        end else if (count >= QD) begin
          drop = 1'b1;
        end else begin
          slots[count] = r.rec;
          count++;
        end
      end else if (count == 0) begin
        busy = 1'b0;
        cur = '0;
      end else begin
        k = choose_slot(r.head, r.scan_up);
        cur = slots[k];
        // entries behind the chosen one close the gap
        for (int j = k; j + 1 < count; j++) slots[j] = slots[j + 1];
        count--;
        busy = 1'b1;
      end
      rep.serving = busy;
      rep.rec = busy ? cur : '0;
      rep.pending = count[4:0];
      rep.dropped = drop;
      due.push_back(rep);
    endfunction

    function void check_report(sched_report_t got);
      sched_report_t want;
      logic [31:0] w[8];
      logic [31:0] g[8];
      string names[8];
      bit bad;
      if (due.size() == 0) begin
        $error("service report with no request waiting");
        errors++;
        return;
      end
      want = due.pop_front();
      names = '{"serving", "id", "arrival", "cylinder", "address", "process",
                "pending", "dropped"};
      w = '{want.serving, want.rec.id, want.rec.arrival, want.rec.cylinder,
            want.rec.address, want.rec.process, want.pending, want.dropped};
      g = '{got.serving, got.rec.id, got.rec.arrival, got.rec.cylinder,
            got.rec.address, got.rec.process, got.pending, got.dropped};
      bad = 1'b0;
      foreach (w[i]) begin
        if (w[i] !== g[i]) begin
          $error("%s mismatch: expected 0x%0h, actual 0x%0h", names[i], w[i], g[i]);
          bad = 1'b1;
        end
      end
      if (bad) errors++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_cmd;
  logic [15:0] in_req_id;
  logic [31:0] in_req_arrival;
  logic [15:0] in_req_cylinder;
  logic [31:0] in_req_address;
  logic [15:0] in_req_process;
  logic [15:0] in_head_cylinder;
  logic        in_scan_up;
  logic        out_valid;
  logic        out_stall;
  logic        out_serving;
  logic [15:0] out_id;
  logic [31:0] out_arrival;
  logic [15:0] out_cylinder;
  logic [31:0] out_address;
  logic [15:0] out_process;
  logic [4:0]  out_pending;
  logic        out_dropped;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sched_scoreboard sb = new();
  bit              no_idle;
  int              reports_seen;
  logic [15:0]     cyl_base;
  logic [31:0]     stamp_base;

  disk_request_scheduler u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_req_id        (in_req_id),
    .in_req_arrival   (in_req_arrival),
    .in_req_cylinder  (in_req_cylinder),
    .in_req_address   (in_req_address),
    .in_req_process   (in_req_process),
    .in_head_cylinder (in_head_cylinder),
    .in_scan_up       (in_scan_up),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_serving      (out_serving),
    .out_id           (out_id),
    .out_arrival      (out_arrival),
    .out_cylinder     (out_cylinder),
    .out_address      (out_address),
    .out_process      (out_process),
    .out_pending      (out_pending),
    .out_dropped      (out_dropped),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // clock
  always #5 clk = ~clk;

  // offer one request, optionally after a short gap, and wait for acceptance
  task automatic send_request(input sched_req_t r);
    if (!no_idle && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_cmd           <= r.cmd;
    in_req_id        <= r.rec.id;
    in_req_arrival   <= r.rec.arrival;
    in_req_cylinder  <= r.rec.cylinder;
    in_req_address   <= r.rec.address;
    in_req_process   <= r.rec.process;
    in_head_cylinder <= r.head;
    in_scan_up       <= r.scan_up;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
    @(negedge clk);
  endtask

  // stop offering and wait for every outstanding report
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.due.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // policy register write: setup then access cycle
  task automatic write_policy(input logic [1:0] code, input logic [29:0] junk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_POLICY, 2'b00};
    pwdata  <= {junk, code};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_policy(code);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // random request biased toward seek ties and same-cylinder hits
  function automatic sched_req_t draw_request(int arrive_pct);
    sched_req_t r;
    int sel;
    r.cmd = ($urandom_range(99) < arrive_pct) ? CMD_ARRIVE : CMD_DONE;
    r.rec.id = 16'($urandom);
    r.rec.address = $urandom;
    r.rec.process = 16'($urandom);
    sel = $urandom_range(3);
    case (sel)
      0: r.rec.cylinder = 16'($urandom);
      1: r.rec.cylinder = cyl_base + 16'($urandom_range(7));
      default: r.rec.cylinder = cyl_base + 16'(2 * $urandom_range(3));
    endcase
    r.rec.arrival = ($urandom_range(1)) ? stamp_base + 32'($urandom_range(3)) : $urandom;
    sel = $urandom_range(9);
    if (sel < 4 && sb.count > 0) r.head = sb.slots[$urandom_range(sb.count - 1)].cylinder;
    else if (sel < 7) r.head = cyl_base + 16'd3;
    else r.head = 16'($urandom);
    r.scan_up = 1'($urandom_range(1));
    return r;
  endfunction

  // result side: random stalls, one long hold-off, check every report
  initial begin
    sched_report_t got;
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !no_idle && ($urandom_range(99) < 12);
      end
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.serving = out_serving;
        got.rec.id = out_id;
        got.rec.arrival = out_arrival;
        got.rec.cylinder = out_cylinder;
        got.rec.address = out_address;
        got.rec.process = out_process;
        got.pending = out_pending;
        got.dropped = out_dropped;
        sb.check_report(got);
        reports_seen++;
        if (reports_seen == HOLD_AT) hold_left = HOLD_CYCLES;
      end
    end
  end

  // run limit
  initial begin
    #(5_000_000);
    $display("end of test: mismatches");
    $finish;
  end

  // main sequence
  initial begin
    sched_req_t r;
    logic [1:0] phase_policy[8];
    int arrive_pct;
    phase_policy = '{POL_SSTF, POL_LOOK, POL_FCFS, 2'd3, POL_LOOK, POL_SSTF, POL_LOOK,
                     POL_FCFS};
    no_idle = 1'b0;
    reports_seen = 0;
    sb.clear_state();
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_cmd           <= CMD_ARRIVE;
    in_req_id        <= '0;
    in_req_arrival   <= '0;
    in_req_cylinder  <= '0;
    in_req_address   <= '0;
    in_req_process   <= '0;
    in_head_cylinder <= '0;
    in_scan_up       <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_policy(POL_FCFS, '0);

    // completion while idle, then an all-zero request that is still served
    r = '0;
    r.cmd = CMD_DONE;
    send_request(r);
    r.cmd = CMD_ARRIVE;
    send_request(r);
    r.cmd = CMD_DONE;
    send_request(r);
    // all-ones request enters service
    r = '1;
    r.cmd = CMD_ARRIVE;
    send_request(r);
    // fill the queue with extreme cylinders and tied stamps
    for (int i = 0; i < QD; i++) begin
      r.cmd = CMD_ARRIVE;
      r.rec.id = 16'(i);
      r.rec.arrival = (i % 4 == 0) ? 32'd0 : 32'hffff_fff0 + 32'(i % 3);
      r.rec.cylinder = 16'(i * 4369);
      r.rec.address = (i % 2) ? 32'hffff_ffff : 32'd0;
      r.rec.process = (i % 2) ? 16'd0 : 16'hffff;
      send_request(r);
    end
    // arrival to a full queue is dropped
    r.rec.id = 16'hdead;
    send_request(r);
    // completions at the head extremes, both directions
    r.cmd = CMD_DONE;
    r.head = 16'hffff;
    r.scan_up = 1'b1;
    send_request(r);
    r.head = 16'h0000;
    r.scan_up = 1'b0;
    send_request(r);
    send_request(r);
    wait_drained();

    // random phases, one policy each
    foreach (phase_policy[p]) begin
      write_policy(phase_policy[p], (p % 2) ? 30'($urandom) : 30'd0);
      cyl_base = (p == 0) ? 16'h0000 : (p == 1) ? 16'hfff8 : 16'($urandom);
      stamp_base = (p == 2) ? 32'hffff_fffc : (p == 3) ? 32'd0 : $urandom;
      no_idle = (p == 4);
      for (int n = 0; n < PHASE_LEN; n++) begin
        // alternate filling and draining stretches
        arrive_pct = ((n / 40) % 2) ? 35 : 75;
        if (p == 2 && n == PHASE_LEN / 2) wait_drained();
        send_request(draw_request(arrive_pct));
      end
      wait_drained();
    end
    no_idle = 1'b0;

    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
